// File: rtl/core/h264_rtp_fu_a_packetizer_unit_defines.svh
// Assertion macros for the H.264 RTP FU-A packetizer.
`ifndef H264_RTP_FU_A_PACKETIZER_UNIT_DEFINES_SVH
`define H264_RTP_FU_A_PACKETIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define H264FU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define H264FU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/h264fu_pkg.sv
// Shared types and constants of the H.264 RTP FU-A packetizer.
`timescale 1ns / 1ps

package h264fu_pkg;

    localparam int LEN_BITS    = 22;
    localparam int FILL_BITS   = 11;
    localparam int ADDR_BITS   = 4;
    localparam int S_DATA_BITS = ((8 + LEN_BITS + 7) / 8) * 8;
    localparam int M_USER_BITS = 3;

    localparam logic [1:0] REG_TS_STEP = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_PTYPE   = 2'd2;
    localparam logic [1:0] REG_SSRC    = 2'd3;

    localparam logic [16:0] TS_STEP_RST = 17'd3600;
    localparam logic [10:0] LIMIT_RST   = 11'd1400;
    localparam logic [6:0]  PTYPE_RST   = 7'd96;
    localparam logic [31:0] SSRC_RST    = 32'd10;

    localparam logic [10:0] MIN_LIMIT = 11'd2;
    localparam logic [7:0]  RTP_V2    = 8'h80;
    localparam logic [7:0]  FU_A_TYPE = 8'd28;
    localparam logic [7:0]  NRI_MASK  = 8'he0;

    localparam logic [3:0] BEAT_FU_IND   = 4'd12;
    localparam logic [3:0] BEAT_FU_HDR   = 4'd13;
    localparam logic [3:0] BEAT_LAST_HDR = 4'd12;
    localparam logic [3:0] BEAT_LAST_FU  = 4'd14;

    typedef struct packed {
        logic [16:0] ts_step;
        logic [10:0] limit;
        logic [6:0]  ptype;
        logic [31:0] ssrc;
    } cfg_t;

    typedef struct packed {
        logic        hdr;
        logic        fu;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        data_end;
        logic        err;
    } plan_t;

endpackage

// File: rtl/core/h264fu_cfg_regs.sv
// APB configuration registers of the packetizer.
`timescale 1ns / 1ps

module h264fu_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [h264fu_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output h264fu_pkg::cfg_t                 cfg
);
    import h264fu_pkg::*;

    logic [16:0] ts_step_reg;
    logic [10:0] limit_reg;
    logic [6:0]  ptype_reg;
    logic [31:0] ssrc_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_step_reg <= TS_STEP_RST;
            limit_reg   <= LIMIT_RST;
            ptype_reg   <= PTYPE_RST;
            ssrc_reg    <= SSRC_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TS_STEP: ts_step_reg <= pwdata[16:0];
                REG_LIMIT:   limit_reg   <= pwdata[10:0];
                REG_PTYPE:   ptype_reg   <= pwdata[6:0];
                REG_SSRC:    ssrc_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TS_STEP: prdata = 32'(ts_step_reg);
            REG_LIMIT:   prdata = 32'(limit_reg);
            REG_PTYPE:   prdata = 32'(ptype_reg);
            REG_SSRC:    prdata = ssrc_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.ts_step = ts_step_reg;
    assign cfg.limit   = limit_reg;
    assign cfg.ptype   = ptype_reg;
    assign cfg.ssrc    = ssrc_reg;

endmodule

// File: rtl/core/h264fu_unit_ctrl.sv
// NAL unit tracking and per-beat packet planning.
`timescale 1ns / 1ps

module h264fu_unit_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_fire,
    input  logic [7:0]                      nal_byte,
    input  logic [h264fu_pkg::LEN_BITS-1:0] nal_length,
    input  h264fu_pkg::cfg_t                cfg,
    output h264fu_pkg::plan_t               plan,
    output logic                            plan_load
);
    import h264fu_pkg::*;

    logic [31:0]          ts_reg,   ts_next;
    logic [15:0]          seq_reg,  seq_next;
    logic [LEN_BITS-1:0]  pos_reg,  pos_next;
    logic [LEN_BITS-1:0]  ulen_reg, ulen_next;
    logic [7:0]           uhdr_reg, uhdr_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic                 frag_reg, frag_next;

    logic [FILL_BITS-1:0] lim;
    logic [LEN_BITS-1:0]  lim_ext;
    logic [LEN_BITS:0]    pos_inc;
    logic [LEN_BITS-1:0]  remain;
    logic [FILL_BITS-1:0] fill_base;
    logic [FILL_BITS-1:0] fill_inc;
    logic [15:0]          seq_inc;
    logic [31:0]          ts_add;
    logic                 idle;
    logic                 last;
    logic                 first_frag;
    logic                 new_frag;
    logic                 e_bit;

    assign lim        = (cfg.limit < MIN_LIMIT) ? MIN_LIMIT : cfg.limit;
    assign lim_ext    = LEN_BITS'(lim);
    assign idle       = (pos_reg == '0);
    assign pos_inc    = {1'b0, pos_reg} + (LEN_BITS+1)'(1);
    assign last       = (pos_inc >= {1'b0, ulen_reg});
    assign remain     = ulen_reg - pos_reg;
    assign first_frag = (pos_reg == LEN_BITS'(1));
    assign new_frag   = first_frag || (fill_reg >= lim);
    assign e_bit      = !first_frag && (remain <= lim_ext);
    assign fill_base  = (new_frag && !first_frag) ? '0 : fill_reg;
    assign fill_inc   = fill_base + FILL_BITS'(1);
    assign seq_inc    = seq_reg + 16'd1;
    assign ts_add     = ts_reg + 32'(cfg.ts_step);

    always_comb begin
        ts_next   = ts_reg;
        seq_next  = seq_reg;
        pos_next  = pos_reg;
        ulen_next = ulen_reg;
        uhdr_next = uhdr_reg;
        fill_next = fill_reg;
        frag_next = frag_reg;
        plan_load = 1'b0;
        plan          = '0;
        plan.seq      = seq_inc;
        plan.ts       = ts_reg;
        plan.data     = nal_byte;
        plan.fu_ind   = (uhdr_reg & NRI_MASK) | FU_A_TYPE;
        plan.fu_hdr   = {first_frag, e_bit, 1'b0, uhdr_reg[4:0]};
        if (in_fire) begin
            if (idle) begin
                ts_next   = ts_add;
                plan.ts   = ts_add;
                ulen_next = nal_length;
                if (nal_length == '0) begin
                    plan_load = 1'b1;
                    plan.err  = 1'b1;
                    plan.data = '0;
                end else begin
                    uhdr_next = nal_byte;
                    if (nal_length > lim_ext) begin
                        frag_next = 1'b1;
                        fill_next = FILL_BITS'(1);
                        pos_next  = LEN_BITS'(1);
                    end else begin
                        frag_next     = 1'b0;
                        seq_next      = seq_inc;
                        plan_load     = 1'b1;
                        plan.hdr      = 1'b1;
                        plan.data_end = (nal_length == LEN_BITS'(1));
                        pos_next      = (nal_length == LEN_BITS'(1)) ? '0 : LEN_BITS'(1);
                    end
                end
            end else if (!frag_reg) begin
                plan_load     = 1'b1;
                plan.data_end = last;
                pos_next      = last ? '0 : pos_inc[LEN_BITS-1:0];
            end else begin
                plan_load = 1'b1;
                if (new_frag) begin
                    seq_next    = seq_inc;
                    plan.hdr    = 1'b1;
                    plan.fu     = 1'b1;
                    plan.marker = e_bit;
                end
                fill_next     = fill_inc;
                plan.data_end = last || (fill_inc >= lim);
                pos_next      = last ? '0 : pos_inc[LEN_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg   <= '0;
            seq_reg  <= '0;
            pos_reg  <= '0;
            ulen_reg <= '0;
            uhdr_reg <= '0;
            fill_reg <= '0;
            frag_reg <= 1'b0;
        end else begin
            ts_reg   <= ts_next;
            seq_reg  <= seq_next;
            pos_reg  <= pos_next;
            ulen_reg <= ulen_next;
            uhdr_reg <= uhdr_next;
            fill_reg <= fill_next;
            frag_reg <= frag_next;
        end
    end

endmodule

// File: rtl/core/h264fu_beat_emit.sv
// Plan register and output register that serialize packet beats.
`timescale 1ns / 1ps

module h264fu_beat_emit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  h264fu_pkg::plan_t                  plan_in,
    input  logic                               plan_load,
    input  h264fu_pkg::cfg_t                   cfg,
    output logic                               in_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,
    output logic                               m_tlast,
    output logic [h264fu_pkg::M_USER_BITS-1:0] m_tuser
);
    import h264fu_pkg::*;

    plan_t                  plan_reg;
    logic                   busy_reg;
    logic [3:0]             idx_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;
    logic                   out_last_reg;
    logic [M_USER_BITS-1:0] out_user_reg;

    logic [3:0] last_idx;
    logic       beat_last;
    logic       out_free;
    logic       advance;
    logic [7:0] beat_byte;

    assign last_idx  = !plan_reg.hdr ? 4'd0 : (plan_reg.fu ? BEAT_LAST_FU : BEAT_LAST_HDR);
    assign beat_last = (idx_reg == last_idx);
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = busy_reg && out_free;
    assign in_ready  = !busy_reg || (advance && beat_last);

    always_comb begin
        beat_byte = plan_reg.data;
        if (plan_reg.hdr) begin
            case (idx_reg)
                4'd0:        beat_byte = RTP_V2;
                4'd1:        beat_byte = {plan_reg.marker, cfg.ptype};
                4'd2:        beat_byte = plan_reg.seq[15:8];
                4'd3:        beat_byte = plan_reg.seq[7:0];
                4'd4:        beat_byte = plan_reg.ts[31:24];
                4'd5:        beat_byte = plan_reg.ts[23:16];
                4'd6:        beat_byte = plan_reg.ts[15:8];
                4'd7:        beat_byte = plan_reg.ts[7:0];
                4'd8:        beat_byte = cfg.ssrc[31:24];
                4'd9:        beat_byte = cfg.ssrc[23:16];
                4'd10:       beat_byte = cfg.ssrc[15:8];
                4'd11:       beat_byte = cfg.ssrc[7:0];
                BEAT_FU_IND: beat_byte = plan_reg.fu ? plan_reg.fu_ind : plan_reg.data;
                BEAT_FU_HDR: beat_byte = plan_reg.fu_hdr;
                default:     beat_byte = plan_reg.data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (plan_load) begin
            plan_reg <= plan_in;
        end
        if (out_free && busy_reg) begin
            out_data_reg <= beat_byte;
            out_last_reg <= beat_last && plan_reg.data_end;
            out_user_reg <= {beat_last, plan_reg.err, plan_reg.hdr && (idx_reg == 4'd0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (plan_load) begin
                busy_reg <= 1'b1;
            end else if (advance && beat_last) begin
                busy_reg <= 1'b0;
            end
            if (advance) begin
                idx_reg <= beat_last ? 4'd0 : idx_reg + 4'd1;
            end
            if (out_free) begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: rtl/core/h264_rtp_fu_a_packetizer_unit.sv
// Top level of the H.264 RTP FU-A packetizer.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: nal_byte, nal_length
//  m_        out  m_tvalid/m_tready  m_tdata: packet_byte; m_tlast: packet_end;
//                                    m_tuser: packet_start, length_error, run_last
//  apb       in   psel/penable       ts step, limit, rtp_pt, ssrc
//
// One beat leaves per cycle while m_tready is high; an input beat yields 0, 1, 13 or 15 output beats.
// Payload bytes pass at one beat per cycle while m_tready is high; a packet header stalls input while it is sent.
// The next input beat is taken in the cycle its predecessor's last output beat is loaded.
// Output beats sit in a register; m_tready low holds it and backs up to s_tready.
// aresetn is synchronous, active low; no clearing pass follows reset.
`timescale 1ns / 1ps
`include "h264_rtp_fu_a_packetizer_unit_defines.svh"

module h264_rtp_fu_a_packetizer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] nal_byte, [29:8] nal_length, [31:30] zero
    input  logic [h264fu_pkg::S_DATA_BITS-1:0] s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] packet_byte
    output logic [7:0]                         m_tdata,
    output logic                               m_tlast,
    // [0] packet_start, [1] length_error, [2] run_last
    output logic [h264fu_pkg::M_USER_BITS-1:0] m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [h264fu_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import h264fu_pkg::*;

    cfg_t  cfg;
    plan_t plan;
    logic  plan_load;
    logic  in_fire;

    assign in_fire = s_tvalid & s_tready;

    h264fu_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    h264fu_unit_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .nal_byte   (s_tdata[7:0]),
        .nal_length (s_tdata[8 +: LEN_BITS]),
        .cfg        (cfg),
        .plan       (plan),
        .plan_load  (plan_load)
    );

    h264fu_beat_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .plan_in   (plan),
        .plan_load (plan_load),
        .cfg       (cfg),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    `H264FU_ASSERT_NOW(a_err_alone, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0] && !m_tlast && m_tuser[2] && (m_tdata == 8'h00), "length error beat carries packet flags")
    `H264FU_ASSERT_NOW(a_start_version, aclk, aresetn, m_tvalid && m_tuser[0], (m_tdata == RTP_V2) && !m_tuser[2] && !m_tlast, "packet start beat is not an RTP version byte")
    `H264FU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output beat changed")

endmodule

// File: sim/h264_rtp_fu_a_packetizer_unit_tb.sv
// Self-checking testbench for the H.264 RTP FU-A packetizer.
`timescale 1ns / 1ps

module h264_rtp_fu_a_packetizer_unit_tb;
    import h264fu_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       pkt_start;
        logic       pkt_end;
        logic       len_err;
        logic       run_last;
    } rtp_beat_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic [M_USER_BITS-1:0] m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_BITS-1:0]   paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    h264_rtp_fu_a_packetizer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the registers and the packetizer state.
    logic [16:0]         ts_step_m;
    logic [10:0]         limit_m;
    logic [6:0]          ptype_m;
    logic [31:0]         ssrc_m;
    logic [31:0]         ts_m;
    logic [15:0]         seq_m;
    logic [LEN_BITS-1:0] pos_m;
    logic [LEN_BITS-1:0] unit_len_m;
    logic [7:0]          nal_hdr_m;
    logic [10:0]         fill_m;
    logic                frag_m;

    rtp_beat_t pending_packet_beats[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned beats_in;
    int unsigned units_seen;
    int unsigned packets_seen;
    int unsigned zero_units_seen;
    int unsigned reg_writes;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void reset_model();
        ts_step_m  = TS_STEP_RST;
        limit_m    = LIMIT_RST;
        ptype_m    = PTYPE_RST;
        ssrc_m     = SSRC_RST;
        ts_m       = '0;
        seq_m      = '0;
        pos_m      = '0;
        unit_len_m = '0;
        nal_hdr_m  = '0;
        fill_m     = '0;
        frag_m     = 1'b0;
    endfunction

    function automatic void emit_beat(logic [7:0] b, logic st, logic en, logic er);
        rtp_beat_t beat;
        beat.pkt_byte  = b;
        beat.pkt_start = st;
        beat.pkt_end   = en;
        beat.len_err   = er;
        beat.run_last  = 1'b0;
        pending_packet_beats.push_back(beat);
    endfunction

    function automatic void emit_rtp_header(logic marker);
        seq_m = seq_m + 16'd1;
        emit_beat(RTP_V2, 1'b1, 1'b0, 1'b0);
        emit_beat({marker, ptype_m}, 1'b0, 1'b0, 1'b0);
        emit_beat(seq_m[15:8], 1'b0, 1'b0, 1'b0);
        emit_beat(seq_m[7:0], 1'b0, 1'b0, 1'b0);
        emit_beat(ts_m[31:24], 1'b0, 1'b0, 1'b0);
        emit_beat(ts_m[23:16], 1'b0, 1'b0, 1'b0);
        emit_beat(ts_m[15:8], 1'b0, 1'b0, 1'b0);
        emit_beat(ts_m[7:0], 1'b0, 1'b0, 1'b0);
        emit_beat(ssrc_m[31:24], 1'b0, 1'b0, 1'b0);
        emit_beat(ssrc_m[23:16], 1'b0, 1'b0, 1'b0);
        emit_beat(ssrc_m[15:8], 1'b0, 1'b0, 1'b0);
        emit_beat(ssrc_m[7:0], 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic void packetize_nal_byte(logic [7:0] b, logic [LEN_BITS-1:0] len);
        int unsigned lim;
        int unsigned p;
        int unsigned n0;
        logic        last;
        logic        fin;
        logic        s_bit;
        logic        e_bit;
        rtp_beat_t   tail;
        n0  = pending_packet_beats.size();
        lim = 32'((limit_m < MIN_LIMIT) ? MIN_LIMIT : limit_m);
        if (pos_m == 0) begin
            unit_len_m = len;
            ts_m = ts_m + ts_step_m;
            units_seen++;
            if (len == 0) begin
                zero_units_seen++;
                emit_beat(8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
                nal_hdr_m = b;
                frag_m = (len > lim);
                if (!frag_m) begin
                    emit_rtp_header(1'b0);
                    emit_beat(b, 1'b0, len == 1, 1'b0);
                    pos_m = (len == 1) ? '0 : LEN_BITS'(1);
                end else begin
                    fill_m = 11'd1;
                    pos_m = LEN_BITS'(1);
                end
            end
        end else if (!frag_m) begin
            last = (pos_m + 1 >= unit_len_m);
            emit_beat(b, 1'b0, last, 1'b0);
            pos_m = last ? '0 : pos_m + 1'b1;
        end else begin
            p = 32'(pos_m);
            last = (p + 1 >= unit_len_m);
            if (p == 1 || fill_m >= lim) begin
                s_bit = (p == 1);
                e_bit = (p != 1) && (unit_len_m - p <= lim);
                emit_rtp_header(e_bit);
                emit_beat((nal_hdr_m & NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0, 1'b0);
                emit_beat({s_bit, e_bit, 1'b0, nal_hdr_m[4:0]}, 1'b0, 1'b0, 1'b0);
                if (p != 1) fill_m = '0;
            end
            fill_m = fill_m + 11'd1;
            fin = last || (fill_m >= lim);
            emit_beat(b, 1'b0, fin, 1'b0);
            pos_m = last ? '0 : pos_m + 1'b1;
        end
        if (pending_packet_beats.size() > n0) begin
            tail = pending_packet_beats.pop_back();
            tail.run_last = 1'b1;
            pending_packet_beats.push_back(tail);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        rtp_beat_t want;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_TS_STEP: ts_step_m = pwdata[16:0];
                    REG_LIMIT:   limit_m   = pwdata[10:0];
                    REG_PTYPE:   ptype_m   = pwdata[6:0];
                    REG_SSRC:    ssrc_m    = pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                beats_in++;
                packetize_nal_byte(s_tdata[7:0], s_tdata[8 +: LEN_BITS]);
            end
            if (m_tvalid && m_tready) begin
                if (pending_packet_beats.size() == 0) begin
                    $error("unexpected output beat: packet_byte %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_packet_beats.pop_front();
                    if (want.pkt_start) packets_seen++;
                    if (m_tdata !== want.pkt_byte) begin
                        $error("packet_byte: expected %h, got %h", want.pkt_byte, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.pkt_start) begin
                        $error("packet_start: expected %b, got %b", want.pkt_start, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.pkt_end) begin
                        $error("packet_end: expected %b, got %b", want.pkt_end, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.len_err) begin
                        $error("length_error: expected %b, got %b", want.len_err, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tuser[2] !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, m_tuser[2]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic [LEN_BITS-1:0] len);
        int unsigned n;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_BITS - 8 - LEN_BITS){1'b0}}, len, b};
        n = beats_in;
        do @(negedge aclk); while (beats_in == n);
    endtask

    // Continuation beats carry random length bits, which the block ignores.
    task automatic send_bytes(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_beat(8'($urandom_range(255)), LEN_BITS'($urandom));
        end
    endtask

    task automatic send_unit(input int unsigned len, input logic [7:0] hdr);
        send_beat(hdr, LEN_BITS'(len));
        if (len > 1) send_bytes(len - 1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_packet_beats.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    task automatic write_random_config();
        case ($urandom_range(2))
            0:       write_reg(REG_TS_STEP, 32'd0);
            1:       write_reg(REG_TS_STEP, 32'd90000);
            default: write_reg(REG_TS_STEP, $urandom_range(131071));
        endcase
        case ($urandom_range(5))
            0:       write_reg(REG_LIMIT, $urandom_range(1));
            1:       write_reg(REG_LIMIT, 32'd2);
            5:       write_reg(REG_LIMIT, $urandom_range(1) ? 32'd1486 : 32'd2047);
            default: write_reg(REG_LIMIT, $urandom_range(12, 3));
        endcase
        write_reg(REG_PTYPE, $urandom_range(127));
        case ($urandom_range(3))
            0:       write_reg(REG_SSRC, 32'd0);
            1:       write_reg(REG_SSRC, 32'hffff_ffff);
            default: write_reg(REG_SSRC, $urandom);
        endcase
    endtask

    task automatic test_reset_defaults();
        send_unit(1, 8'h00);
        send_unit(0, 8'hff);
        send_unit(2, 8'h65);
        wait_idle();
    endtask

    task automatic test_fragmentation();
        write_reg(REG_LIMIT, 32'd4);
        send_unit(6, 8'hff);
        send_unit(4, 8'h41);
        wait_idle();
    endtask

    task automatic test_small_limit();
        write_reg(REG_LIMIT, 32'd1);
        send_unit(3, 8'h7c);
        wait_idle();
        write_reg(REG_LIMIT, 32'd0);
    endtask

    task automatic test_limit_mid_unit();
        write_reg(REG_LIMIT, 32'd3);
        send_beat(8'h85, LEN_BITS'(6));
        send_bytes(2);
        wait_idle();
        write_reg(REG_LIMIT, 32'd5);
        send_bytes(3);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_TS_STEP, 32'h0001_ffff);
        write_reg(REG_LIMIT, 32'd2047);
        write_reg(REG_PTYPE, 32'd127);
        write_reg(REG_SSRC, 32'hffff_ffff);
        send_unit(2, 8'h06);
        wait_idle();
        write_reg(REG_TS_STEP, 32'd0);
        write_reg(REG_LIMIT, 32'd2);
        write_reg(REG_PTYPE, 32'd0);
        write_reg(REG_SSRC, 32'd0);
        send_unit(1, 8'h09);
        wait_idle();
    endtask

    task automatic test_random_units(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_beats);
        int unsigned sent;
        int unsigned len;
        int unsigned lim_eff;
        int unsigned max_len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_random_config();
        sent = 0;
        while (sent < n_beats) begin
            lim_eff = 32'((limit_m < MIN_LIMIT) ? MIN_LIMIT : limit_m);
            max_len = (3 * lim_eff + 2 > 40) ? 40 : 3 * lim_eff + 2;
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(max_len, 1);
            send_unit(len, 8'($urandom_range(255)));
            sent += (len == 0) ? 1 : len;
            if ($urandom_range(4) == 0) begin
                wait_idle();
                write_random_config();
            end
        end
        wait_idle();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_LIMIT, 32'd4);
        hold_left = 300;
        send_unit(20, 8'h65);
        wait_idle();
    endtask

    // Leave a maximal-length unit open; only its opening fragment is checked.
    task automatic test_long_unit();
        write_reg(REG_LIMIT, 32'd1486);
        send_beat(8'h25, {LEN_BITS{1'b1}});
        send_bytes(15);
        wait_idle();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        send_idle_pct   = 36;
        recv_idle_pct   = 52;
        hold_left       = 0;
        cycle_count     = 0;
        fail_count      = 0;
        beats_in        = 0;
        units_seen      = 0;
        packets_seen    = 0;
        zero_units_seen = 0;
        reg_writes      = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_fragmentation();
        test_small_limit();
        test_limit_mid_unit();
        test_register_extremes();
        test_random_units(36, 52, 30);
        test_random_units(52, 36, 30);
        test_random_units(0, 0, 25);
        test_output_stall();
        test_long_unit();

        $display("Run covered %0d input beats in %0d NAL units (%0d zero-length),",
                 beats_in, units_seen, zero_units_seen);
        $display("%0d RTP packets, %0d register writes, FU-A splits and output stalls.",
                 packets_seen, reg_writes);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: h264_rtp_fu_a_packetizer_unit.f
+incdir+rtl/core
rtl/core/h264fu_pkg.sv
rtl/core/h264fu_cfg_regs.sv
rtl/core/h264fu_unit_ctrl.sv
rtl/core/h264fu_beat_emit.sv
rtl/core/h264_rtp_fu_a_packetizer_unit.sv
sim/h264_rtp_fu_a_packetizer_unit_tb.sv
